@@ design/sdel_pkg.sv @@
package sdel_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] CMD_SORTED = 2'd0;
  localparam logic [1:0] CMD_AT     = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        item;
    logic [15:0]        stage;
    logic               flag;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             insert_en;
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] count;
    entry_t           ent;
  } cell_bcast_t;

endpackage

@@ design/sorted_descending_entry_list.sv @@
// Sorted entry list, one entry per cell of a shifting register chain.
// Insert at position, read and membership query are decided in the execute
// state; a sorted insert then runs a binary search (at most 6 steps, since
// at most 63 entries are searched) and places the entry once it converges.
// One transaction in flight; the next is taken at the edge that ends its done
// strobe, and the receiver cannot stall. Reset (rst, sync) empties the list.
module sorted_descending_entry_list (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [6:0]                   position,
  input  logic signed [31:0]           entry_value,
  input  logic [15:0]                  entry_item,
  input  logic [15:0]                  entry_stage,
  input  logic                         entry_flag,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [6:0]                   where_put,
  output logic [6:0]                   fill_count,
  output logic                         found,
  output logic signed [31:0]           read_value,
  output logic [15:0]                  read_item,
  output logic [15:0]                  read_stage,
  output logic                         read_flag
);

  localparam int CAP   = sdel_pkg::CAPACITY;
  localparam int IDX_W = sdel_pkg::IDX_W;
  localparam int CNT_W = sdel_pkg::CNT_W;
  localparam int POS_W = sdel_pkg::POS_W;
  localparam int CMP_W = sdel_pkg::CMP_W;

  // controller states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // latched transaction
  logic [1:0]         cmd_q;
  logic [POS_W-1:0]   pos_q;
  sdel_pkg::entry_t   ent_q;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  // cell chain
  sdel_pkg::cell_bcast_t bc;
  sdel_pkg::entry_t      cell_q [CAP];
  logic [CAP-1:0]        match_vec;

  // search unit
  logic              srch_init;
  logic              srch_step;
  logic [IDX_W-1:0]  srch_mid;
  logic [CNT_W-1:0]  srch_lo;
  logic              srch_done;

  // shared read port
  logic [IDX_W-1:0]  rd_addr;
  sdel_pkg::entry_t  rd_ent;

  // result
  logic              res_load;
  logic [1:0]        status_next;
  logic [POS_W-1:0]  where_next;
  logic              found_next;
  sdel_pkg::entry_t  read_next;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q       <= cmd;
      pos_q       <= position;
      ent_q.value <= entry_value;
      ent_q.item  <= entry_item;
      ent_q.stage <= entry_stage;
      ent_q.flag  <= entry_flag;
    end
  end

  // Chain of cells: each holds one position; on an insert the cells above
  // the target take their lower neighbor, all in the same cycle.
  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      sdel_pkg::entry_t prev;
      if (g == 0) begin : g_first
        assign prev = '0;
      end else begin : g_rest
        assign prev = cell_q[g-1];
      end
      sdel_cell u_cell (
        .clk   (clk),
        .bc    (bc),
        .index (IDX_W'(g)),
        .prev  (prev),
        .ent   (cell_q[g]),
        .match (match_vec[g])
      );
    end
  endgenerate

  // One read mux serves both reads and the search probe.
  assign rd_addr = (state == S_SEARCH) ? srch_mid : pos_q[IDX_W-1:0];
  assign rd_ent  = cell_q[rd_addr];

  sdel_search u_search (
    .clk        (clk),
    .rst        (rst),
    .init       (srch_init),
    .step       (srch_step),
    .pos        (pos_q),
    .count      (count),
    .value      (ent_q.value),
    .key_at_mid (rd_ent.value),
    .mid        (srch_mid),
    .lo_out     (srch_lo),
    .done       (srch_done)
  );

  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CNT_W'(CAP));

  always_comb begin
    state_next   = state;
    count_next   = count;
    bc.count     = count;
    bc.ent       = ent_q;
    bc.insert_en = 1'b0;
    bc.at        = pos_q[IDX_W-1:0];
    srch_init    = 1'b0;
    srch_step    = 1'b0;
    res_load     = 1'b0;
    status_next  = sdel_pkg::ST_OK;
    where_next   = '0;
    found_next   = 1'b0;
    read_next    = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        case (cmd_q)
          sdel_pkg::CMD_SORTED: begin
            if (full) begin
              res_load    = 1'b1;
              status_next = sdel_pkg::ST_FULL;
            end else begin
              srch_init  = 1'b1;
              state_next = S_SEARCH;
            end
          end
          sdel_pkg::CMD_AT: begin
            res_load = 1'b1;
            if (full) begin
              status_next = sdel_pkg::ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              status_next = sdel_pkg::ST_BAD;
            end else begin
              bc.insert_en = 1'b1;
              count_next   = count + 1'b1;
              where_next   = pos_q;
            end
          end
          sdel_pkg::CMD_READ: begin
            res_load = 1'b1;
            if (pos_ext >= cnt_ext) begin
              status_next = sdel_pkg::ST_BAD;
            end else begin
              where_next = pos_q;
              read_next  = rd_ent;
            end
          end
          default: begin
            res_load   = 1'b1;
            found_next = |match_vec;
          end
        endcase
      end

      S_SEARCH: begin
        if (srch_done) begin
          // search converged: place the entry at lo
          bc.insert_en = 1'b1;
          bc.at        = srch_lo[IDX_W-1:0];
          count_next   = count + 1'b1;
          res_load     = 1'b1;
          where_next   = POS_W'(srch_lo);
          state_next   = S_IDLE;
        end else begin
          srch_step = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_load;
    end
  end

  // result registers, shown for the single strobe cycle
  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= status_next;
      where_put  <= where_next;
      fill_count <= POS_W'(count_next);
      found      <= found_next;
      read_value <= read_next.value;
      read_item  <= read_next.item;
      read_stage <= read_next.stage;
      read_flag  <= read_next.flag;
    end
  end

endmodule

@@ design/sdel_cell.sv @@
module sdel_cell (
  input  logic                                clk,
  input  sdel_pkg::cell_bcast_t               bc,
  input  logic [sdel_pkg::IDX_W-1:0]          index,
  input  sdel_pkg::entry_t                    prev,
  output sdel_pkg::entry_t                    ent,
  output logic                                match
);

  // new entry lands here, cells above take their lower neighbor
  always_ff @(posedge clk) begin
    if (bc.insert_en) begin
      if (index == bc.at) begin
        ent <= bc.ent;
      end else if (index > bc.at) begin
        ent <= prev;
      end
    end
  end

  // membership compare on value and both tags; flag ignored
  assign match = (sdel_pkg::CNT_W'(index) < bc.count) &&
                 (ent.value == bc.ent.value) &&
                 (ent.item == bc.ent.item) &&
                 (ent.stage == bc.ent.stage);

endmodule

@@ design/sdel_search.sv @@
module sdel_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              init,
  input  logic                              step,
  input  logic [sdel_pkg::POS_W-1:0]        pos,
  input  logic [sdel_pkg::CNT_W-1:0]        count,
  input  logic signed [31:0]                value,
  input  logic signed [31:0]                key_at_mid,
  output logic [sdel_pkg::IDX_W-1:0]        mid,
  output logic [sdel_pkg::CNT_W-1:0]        lo_out,
  output logic                              done
);

  logic [sdel_pkg::CNT_W-1:0] lo;
  logic [sdel_pkg::CNT_W-1:0] hi;
  logic [sdel_pkg::CNT_W:0]   sum;
  logic [sdel_pkg::CNT_W-1:0] mid_full;
  logic [sdel_pkg::CMP_W-1:0] pos_ext;
  logic [sdel_pkg::CMP_W-1:0] cnt_ext;
  logic                       use_pos;

  assign sum      = {1'b0, lo} + {1'b0, hi};
  assign mid_full = sum[sdel_pkg::CNT_W:1];
  assign mid      = mid_full[sdel_pkg::IDX_W-1:0];
  assign done     = (lo >= hi);
  assign lo_out   = lo;

  assign pos_ext = sdel_pkg::CMP_W'(pos);
  assign cnt_ext = sdel_pkg::CMP_W'(count);
  // start position honored only strictly inside the list
  assign use_pos = (pos_ext != '0) && (pos_ext < cnt_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else if (init) begin
      lo <= use_pos ? sdel_pkg::CNT_W'(pos) : '0;
      hi <= count;
    end else if (step) begin
      if (value > key_at_mid) begin
        hi <= mid_full;
      end else begin
        lo <= mid_full + 1'b1;
      end
    end
  end

endmodule

@@ tb/sorted_descending_entry_list_tb.sv @@
`timescale 1ns / 100ps

// Checks sorted_descending_entry_list against a shadow copy of the list kept
// in the testbench. The shadow list is updated once per accepted transaction,
// and the response it gives is queued. Each done strobe is checked field by
// field against the oldest queued response.
//
// Flow: directed transactions on an empty and a nearly empty list, then a
// long random mix that fills the list gradually, then a fill to capacity so
// that refused inserts are seen. There is no delete command and reset is only
// asserted once, so the list only grows over the run.
module sorted_descending_entry_list_tb;

  localparam int WATCHDOG_CYCLES = 2000;  // cycles with no traffic at all
  localparam int TAIL_CYCLES     = 20;    // longer than the slowest sorted insert

  typedef struct {
    logic [1:0]         status;
    logic [6:0]         where_put;
    logic [6:0]         fill_count;
    logic               found;
    logic signed [31:0] read_value;
    logic [15:0]        read_item;
    logic [15:0]        read_stage;
    logic               read_flag;
  } list_response_t;

  // value plus both tags: what a membership query compares
  typedef struct {
    logic signed [31:0] value;
    logic [15:0]        item;
    logic [15:0]        stage;
  } entry_key_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = sdel_pkg::CMD_READ;
  logic [6:0]         position = '0;
  logic signed [31:0] entry_value = '0;
  logic [15:0]        entry_item = '0;
  logic [15:0]        entry_stage = '0;
  logic               entry_flag = 1'b0;
  logic               done;
  logic [1:0]         status;
  logic [6:0]         where_put;
  logic [6:0]         fill_count;
  logic               found;
  logic signed [31:0] read_value;
  logic [15:0]        read_item;
  logic [15:0]        read_stage;
  logic               read_flag;

  // shadow copy of the list contents
  logic signed [31:0] shadow_value [sdel_pkg::CAPACITY];
  logic [15:0]        shadow_item  [sdel_pkg::CAPACITY];
  logic [15:0]        shadow_stage [sdel_pkg::CAPACITY];
  logic               shadow_flag  [sdel_pkg::CAPACITY];
  int                 shadow_count = 0;

  list_response_t pending_responses [$];
  entry_key_t     written_entries [$];  // candidates for query hits
  int             error_count = 0;
  int             quiet_cycles = 0;

  always #6 clk = ~clk;

  sorted_descending_entry_list uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .position    (position),
    .entry_value (entry_value),
    .entry_item  (entry_item),
    .entry_stage (entry_stage),
    .entry_flag  (entry_flag),
    .done        (done),
    .status      (status),
    .where_put   (where_put),
    .fill_count  (fill_count),
    .found       (found),
    .read_value  (read_value),
    .read_item   (read_item),
    .read_stage  (read_stage),
    .read_flag   (read_flag)
  );

  // Applies one command to the shadow list and returns the response the
  // block must give for it.
  function automatic list_response_t list_response(
    input logic [1:0] op, input logic [6:0] pos, input logic signed [31:0] v,
    input logic [15:0] it, input logic [15:0] st, input logic fl);
    list_response_t r;
    int  lo;
    int  hi;
    int  mid;
    int  at;
    int  i;
    bit  do_put;
    r = '{default: '0};
    do_put = 1'b0;
    at = 0;
    case (op)
      sdel_pkg::CMD_SORTED: begin
        if (shadow_count >= sdel_pkg::CAPACITY) begin
          r.status = sdel_pkg::ST_FULL;
        end else begin
          // search start hint only counts strictly inside the list
          lo = 0;
          hi = shadow_count;
          if (pos > 0 && pos < hi) lo = pos;
          // plain binary search, even if an insert at position broke order;
          // equal values fall through to the right
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (v > shadow_value[mid]) hi = mid;
            else lo = mid + 1;
          end
          at = lo;
          do_put = 1'b1;
        end
      end
      sdel_pkg::CMD_AT: begin
        // full is checked before the range
        if (shadow_count >= sdel_pkg::CAPACITY) r.status = sdel_pkg::ST_FULL;
        else if (pos > shadow_count) r.status = sdel_pkg::ST_BAD;
        else begin
          at = pos;
          do_put = 1'b1;
        end
      end
      sdel_pkg::CMD_READ: begin
        if (pos >= shadow_count) begin
          r.status = sdel_pkg::ST_BAD;
        end else begin
          r.where_put  = pos;
          r.read_value = shadow_value[pos];
          r.read_item  = shadow_item[pos];
          r.read_stage = shadow_stage[pos];
          r.read_flag  = shadow_flag[pos];
        end
      end
      default: begin
        // membership: value and both tags, flag ignored
        for (i = 0; i < shadow_count; i++)
          if (shadow_value[i] == v && shadow_item[i] == it && shadow_stage[i] == st)
            r.found = 1'b1;
      end
    endcase
    if (do_put) begin
      for (i = shadow_count; i > at; i--) begin
        shadow_value[i] = shadow_value[i-1];
        shadow_item[i]  = shadow_item[i-1];
        shadow_stage[i] = shadow_stage[i-1];
        shadow_flag[i]  = shadow_flag[i-1];
      end
      shadow_value[at] = v;
      shadow_item[at]  = it;
      shadow_stage[at] = st;
      shadow_flag[at]  = fl;
      shadow_count++;
      r.where_put = 7'(at);
    end
    r.fill_count = 7'(shadow_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      error_count++;
    end
  endtask

  // Monitor, response checker and watchdog. Inputs and outputs are sampled at
  // the rising edge, before the nonblocking updates of that edge land.
  always @(posedge clk) begin
    list_response_t want;
    bit             took;
    took = !rst && start && !busy;
    // pop before push: a done strobe always belongs to an earlier transaction
    if (!rst && done) begin
      if (pending_responses.size() == 0) begin
        $error("done strobe with no transaction outstanding");
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("status",     want.status,     status);
        check_field("where_put",  want.where_put,  where_put);
        check_field("fill_count", want.fill_count, fill_count);
        check_field("found",      want.found,      found);
        check_field("read_value", want.read_value, read_value);
        check_field("read_item",  want.read_item,  read_item);
        check_field("read_stage", want.read_stage, read_stage);
        check_field("read_flag",  want.read_flag,  read_flag);
      end
    end
    if (took) begin
      want = list_response(cmd, position, entry_value, entry_item, entry_stage,
                           entry_flag);
      pending_responses.insert(pending_responses.size(), want);
    end
    if (took || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $error("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one transaction and returns at the edge that accepts it. Start
  // stays high, so back-to-back calls give a continuous stream.
  task automatic issue_command(input logic [1:0] op, input logic [6:0] pos,
                               input logic signed [31:0] v, input logic [15:0] it,
                               input logic [15:0] st, input logic fl);
    start       <= 1'b1;
    cmd         <= op;
    position    <= pos;
    entry_value <= v;
    entry_item  <= it;
    entry_stage <= st;
    entry_flag  <= fl;
    if (op == sdel_pkg::CMD_SORTED || op == sdel_pkg::CMD_AT)
      written_entries.insert(written_entries.size(), entry_key_t'{v, it, st});
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // sender holds off until every outstanding response is back
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small pool makes equal values common, so ties in the search get exercised
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 6)) - 3;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // reads, queries and bad inserts on the empty list
  task automatic test_empty_list();
    issue_command(sdel_pkg::CMD_READ,  7'd0,  32'sd0, 16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_READ,  7'd64, 32'sd0, 16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_QUERY, 7'd0,  32'sd0, 16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_AT,    7'd1,  32'sd5, 16'h1234, 16'h5678, 1'b1);
    issue_command(sdel_pkg::CMD_AT,    7'd64, 32'sd5, 16'h1234, 16'h5678, 1'b1);
  endtask

  // extreme values and tags, tie placement, search hint, broken ordering
  task automatic test_extreme_entries();
    issue_command(sdel_pkg::CMD_AT,     7'd0,  32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    issue_command(sdel_pkg::CMD_SORTED, 7'd64, 32'sh8000_0000, 16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_SORTED, 7'd1,  32'sd0,         16'h00FF, 16'hFF00, 1'b1);
    issue_command(sdel_pkg::CMD_SORTED, 7'd0,  32'sh7FFF_FFFF, 16'h0001, 16'h0002, 1'b0);
    issue_command(sdel_pkg::CMD_SORTED, 7'd3,  -32'sd1,        16'hA5A5, 16'h5A5A, 1'b1);
    // append a large value at the tail: list is no longer sorted
    issue_command(sdel_pkg::CMD_AT,     7'd5,  32'sd100,       16'h0F0F, 16'hF0F0, 1'b0);
    issue_command(sdel_pkg::CMD_SORTED, 7'd0,  32'sd50,        16'h3333, 16'hCCCC, 1'b1);
    issue_command(sdel_pkg::CMD_AT,     7'd8,  32'sd7,         16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_READ,   7'd0,  32'sd0,         16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_READ,   7'd6,  32'sd0,         16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_READ,   7'd7,  32'sd0,         16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_QUERY,  7'd0,  32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    issue_command(sdel_pkg::CMD_QUERY,  7'd0,  32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFE, 1'b1);
    issue_command(sdel_pkg::CMD_QUERY,  7'd0,  32'sh7FFF_FFFE, 16'hFFFF, 16'hFFFF, 1'b0);
  endtask

  // Random mix. Inserts are about one in six, so the list fills late in the
  // run and refused inserts show up near the end.
  task automatic test_random_mix(input int count);
    entry_key_t         e;
    logic [6:0]         pos;
    logic [15:0]        it;
    logic [15:0]        st;
    logic               fl;
    bit                 steady;
    int                 r;
    steady = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);  // no-gap stretch
      if (k % 150 == 149) pause_until_drained();
      r  = $urandom_range(0, 99);
      it = 16'($urandom_range(0, 16'hFFFF));
      st = 16'($urandom_range(0, 16'hFFFF));
      fl = 1'($urandom_range(0, 1));
      // shadow_count only steers the stimulus; it may lag by a transaction
      if (r < 10) begin
        pos = $urandom_range(0, 1) ? 7'($urandom_range(0, shadow_count))
                                   : 7'($urandom_range(0, 64));
        issue_command(sdel_pkg::CMD_SORTED, pos, pick_value(), it, st, fl);
      end else if (r < 16) begin
        pos = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 64))
                                          : 7'($urandom_range(0, shadow_count));
        issue_command(sdel_pkg::CMD_AT, pos, pick_value(), it, st, fl);
      end else if (r < 55) begin
        pos = (shadow_count > 0 && $urandom_range(0, 6) != 0)
              ? 7'($urandom_range(0, shadow_count - 1)) : 7'($urandom_range(0, 64));
        issue_command(sdel_pkg::CMD_READ, pos, pick_value(), it, st, fl);
      end else begin
        pos = 7'($urandom_range(0, 64));
        if (written_entries.size() > 0 && $urandom_range(0, 9) < 7) begin
          e = written_entries[$urandom_range(0, written_entries.size() - 1)];
          // near miss on one tag bit now and then
          if ($urandom_range(0, 3) == 0) e.stage ^= 16'(1 << $urandom_range(0, 15));
          issue_command(sdel_pkg::CMD_QUERY, pos, e.value, e.item, e.stage, fl);
        end else begin
          issue_command(sdel_pkg::CMD_QUERY, pos, pick_value(), it, st, fl);
        end
      end
      if (!steady) idle_for(gap_length());
    end
  endtask

  // fill to capacity, then inserts of both kinds must be refused
  task automatic test_full_list();
    entry_key_t e;
    for (int k = 0; k < sdel_pkg::CAPACITY + 6; k++) begin
      issue_command(sdel_pkg::CMD_SORTED, 7'($urandom_range(0, 64)), pick_value(),
                    16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                    1'($urandom_range(0, 1)));
      idle_for(gap_length());
    end
    issue_command(sdel_pkg::CMD_AT,     7'd0,  32'sd1, 16'h0001, 16'h0001, 1'b1);
    issue_command(sdel_pkg::CMD_AT,     7'd64, 32'sd1, 16'h0001, 16'h0001, 1'b1);
    issue_command(sdel_pkg::CMD_SORTED, 7'd64, 32'sd1, 16'h0001, 16'h0001, 1'b1);
    issue_command(sdel_pkg::CMD_READ,   7'd63, 32'sd0, 16'h0000, 16'h0000, 1'b0);
    issue_command(sdel_pkg::CMD_READ,   7'd64, 32'sd0, 16'h0000, 16'h0000, 1'b0);
    e = written_entries[written_entries.size() - 4];
    issue_command(sdel_pkg::CMD_QUERY,  7'd0,  e.value, e.item, e.stage, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_extreme_entries();
    pause_until_drained();
    test_random_mix(500);
    test_full_list();
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $error("%0d responses never arrived", pending_responses.size());
      error_count++;
    end
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
